### hw/rtl/jadc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jadc_pkg
// Shared types and constants for the joystick axis duty and cursor block.
// ----------------------------------------------------------------------------
package jadc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 7;
    localparam int OFF_W    = 5;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 6;
    localparam int IDX_W    = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] CFG_TOP_X    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_BOTTOM_X = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TOP_Y    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_BOTTOM_Y = 3'd5;

    localparam logic [SAMPLE_W-1:0] CENTER_RST = 12'd2047;
    localparam logic [SAMPLE_W-1:0] TOP_RST    = 12'd4095;
    localparam logic [SAMPLE_W-1:0] BOTTOM_RST = 12'd0;

    localparam logic [COL_W-1:0]   COL_REST  = 7'd100;
    localparam logic [ROW_W-1:0]   ROW_REST  = 6'd46;
    localparam logic [OFF_W-1:0]   COL_SWING = 5'd16;
    localparam logic [OFF_W-1:0]   ROW_SWING = 5'd9;
    localparam logic [LEVEL_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [LEVEL_W-1:0] DUTY_MIN  = 7'd10;

    // what one axis lane hands to the merge stage
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [OFF_W-1:0]   off;
        logic               neg;    // sample was below center
        logic               moved;
    } t_lane_res;

endpackage
`default_nettype wire

### hw/rtl/jadc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jadc_lane
// One axis: change rule, held sample, deflection and a restoring divider
// that produces first the duty quotient and then the cursor offset quotient.
// ----------------------------------------------------------------------------
module jadc_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [jadc_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic [jadc_pkg::SAMPLE_W-1:0]       i_center,
    input  logic [jadc_pkg::SAMPLE_W-1:0]       i_top,
    input  logic [jadc_pkg::SAMPLE_W-1:0]       i_bottom,
    input  logic [jadc_pkg::OFF_W-1:0]          i_swing,
    output logic                                o_done,
    output jadc_pkg::t_lane_res                 o_res
);
    import jadc_pkg::*;

    localparam int NUM_W = 19;               // 4095 * 100 fits
    localparam logic [2:0] DUTY_TOP_BIT  = 3'd6;
    localparam logic [2:0] SWING_TOP_BIT = 3'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DUTY  = 4'b0010,
        S_SWING = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [SAMPLE_W-1:0]   r_held, n_held;
    t_lane_res             r_res, n_res;
    logic [SAMPLE_W-1:0]   r_dev, n_dev;
    logic [SAMPLE_W-1:0]   r_span, n_span;
    logic [NUM_W-1:0]      r_num, n_num;
    logic [LEVEL_W-1:0]    r_q, n_q;
    logic [2:0]            r_bit, n_bit;

    logic [SAMPLE_W-1:0]   diff;
    logic [SAMPLE_W+4:0]   diff20;
    logic                  pass;
    logic                  below;
    logic [SAMPLE_W-1:0]   dev;
    logic [SAMPLE_W-1:0]   span;
    logic                  sat;
    logic [NUM_W-1:0]      shifted;
    logic                  ge;
    logic [NUM_W-1:0]      num_step;
    logic [LEVEL_W-1:0]    q_step;

    always_comb begin
        diff   = (r_held > i_sample) ? (r_held - i_sample) : (i_sample - r_held);
        diff20 = {1'b0, diff, 4'b0} + {3'b0, diff, 2'b0};
        pass   = diff20 > {5'b0, r_held};
        below  = i_sample < i_center;
        if (below) begin
            dev  = i_center - i_sample;
            span = (i_bottom < i_center) ? (i_center - i_bottom) : '0;
        end else begin
            dev  = i_sample - i_center;
            span = (i_top > i_center) ? (i_top - i_center) : '0;
        end
        sat = (span == '0) || (dev >= span);
    end

    // one restoring quotient bit per cycle
    always_comb begin
        shifted  = NUM_W'(r_span) << r_bit;
        ge       = r_num >= shifted;
        num_step = ge ? (r_num - shifted) : r_num;
        q_step   = r_q | (LEVEL_W'(ge) << r_bit);
    end

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        n_res   = r_res;
        n_dev   = r_dev;
        n_span  = r_span;
        n_num   = r_num;
        n_q     = r_q;
        n_bit   = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state   = S_DONE;
                    n_res.moved = pass;
                    if (pass) begin
                        n_held = i_sample;
                    end
                    if (pass && (i_center != '0)) begin
                        if (i_sample == i_center) begin
                            n_res.level = '0;
                            n_res.off   = '0;
                            n_res.neg   = 1'b0;
                        end else if (sat) begin
                            n_res.level = DUTY_FULL;
                            n_res.off   = i_swing;
                            n_res.neg   = below;
                        end else begin
                            n_res.neg = below;
                            n_dev     = dev;
                            n_span    = span;
                            n_num     = NUM_W'(dev) * NUM_W'(DUTY_FULL);
                            n_q       = '0;
                            n_bit     = DUTY_TOP_BIT;
                            n_state   = S_DUTY;
                        end
                    end
                end
            end
            S_DUTY: begin
                n_num = num_step;
                n_q   = q_step;
                n_bit = r_bit - 3'd1;
                if (r_bit == '0) begin
                    n_res.level = (q_step < DUTY_MIN) ? '0 : q_step;
                    n_num       = NUM_W'(r_dev) * NUM_W'(i_swing);
                    n_q         = '0;
                    n_bit       = SWING_TOP_BIT;
                    n_state     = S_SWING;
                end
            end
            S_SWING: begin
                n_num = num_step;
                n_q   = q_step;
                n_bit = r_bit - 3'd1;
                if (r_bit == '0) begin
                    n_res.off = q_step[OFF_W-1:0];
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= CENTER_RST;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dev  <= n_dev;
        r_span <= n_span;
        r_num  <= n_num;
        r_q    <= n_q;
        r_bit  <= n_bit;
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule
`default_nettype wire

### hw/rtl/joystick_axis_duty_and_cursor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_axis_duty_and_cursor
// Joystick sample pair in; duty per axis, cursor position and change flags out.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one request of two 12-bit samples.
// Output channel: o_valid / i_stall carries one result per request.
// A request transfers on a clock edge with valid high and stall low.
// The x and y lanes run side by side; the merge stage waits for both and
// loads the output register, then the next request is taken.
// No division is needed when the change rule sees no move, the sample is at
// center, the center is zero or the deflection saturates; otherwise each lane's
// shared restoring divider forms 7 duty quotient bits, then 4 cursor quotient bits.
// A new request is taken only after the previous one has loaded the output register.
// A finished result waits in the output register while the next request is
// already processed; if the receiver stalls, the lanes hold their result and
// o_stall stays high until the output register frees.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once;
// indexes above 5 are dropped. Reset (synchronous, active low) restores
// calibration defaults, held samples of 2047 and zero lane results, but not the output registers.
// ----------------------------------------------------------------------------
module joystick_axis_duty_and_cursor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [jadc_pkg::SAMPLE_W-1:0]   i_sample_x,
    input  logic [jadc_pkg::SAMPLE_W-1:0]   i_sample_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [jadc_pkg::LEVEL_W-1:0]    o_duty_x,
    output logic [jadc_pkg::LEVEL_W-1:0]    o_duty_y,
    output logic [jadc_pkg::COL_W-1:0]      o_cursor_col,
    output logic [jadc_pkg::ROW_W-1:0]      o_cursor_row,
    output logic                            o_moved_x,
    output logic                            o_moved_y,
    input  logic                            i_cfg_we,
    input  logic [jadc_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [jadc_pkg::SAMPLE_W-1:0]   i_cfg_data
);
    import jadc_pkg::*;

    logic [SAMPLE_W-1:0] r_center_x, r_top_x, r_bottom_x;
    logic [SAMPLE_W-1:0] r_center_y, r_top_y, r_bottom_y;

    logic r_busy, n_busy;
    logic r_done_x, n_done_x;
    logic r_done_y, n_done_y;
    logic r_out_valid, n_out_valid;

    logic [LEVEL_W-1:0] r_duty_x, r_duty_y;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_moved_x, r_moved_y;

    logic      accept;
    logic      load;
    logic      both_done;
    logic      done_x, done_y;
    t_lane_res res_x, res_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_RST;
            r_top_x    <= TOP_RST;
            r_bottom_x <= BOTTOM_RST;
            r_center_y <= CENTER_RST;
            r_top_y    <= TOP_RST;
            r_bottom_y <= BOTTOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_TOP_X:    r_top_x    <= i_cfg_data;
                CFG_BOTTOM_X: r_bottom_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_TOP_Y:    r_top_y    <= i_cfg_data;
                CFG_BOTTOM_Y: r_bottom_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_valid && !r_busy;

    jadc_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_sample (i_sample_x),
        .i_center (r_center_x),
        .i_top    (r_top_x),
        .i_bottom (r_bottom_x),
        .i_swing  (COL_SWING),
        .o_done   (done_x),
        .o_res    (res_x)
    );

    jadc_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_sample (i_sample_y),
        .i_center (r_center_y),
        .i_top    (r_top_y),
        .i_bottom (r_bottom_y),
        .i_swing  (ROW_SWING),
        .o_done   (done_y),
        .o_res    (res_y)
    );

    // merge: lane results stay put after done until the next start
    always_comb begin
        both_done   = (r_done_x || done_x) && (r_done_y || done_y);
        load        = r_busy && both_done && (!r_out_valid || !i_stall);
        n_done_x    = (r_done_x || done_x) && !load;
        n_done_y    = (r_done_y || done_y) && !load;
        n_busy      = (r_busy || accept) && !load;
        n_out_valid = load || (r_out_valid && i_stall);
        n_col = res_x.neg ? (COL_REST - COL_W'(res_x.off)) : (COL_REST + COL_W'(res_x.off));
        // row grows downward, i.e. for a sample below center
        n_row = res_y.neg ? (ROW_REST + ROW_W'(res_y.off)) : (ROW_REST - ROW_W'(res_y.off));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done_x    <= 1'b0;
            r_done_y    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_done_x    <= n_done_x;
            r_done_y    <= n_done_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_duty_x  <= res_x.level;
            r_duty_y  <= res_y.level;
            r_col     <= n_col;
            r_row     <= n_row;
            r_moved_x <= res_x.moved;
            r_moved_y <= res_y.moved;
        end
    end

    assign o_stall      = r_busy;
    assign o_valid      = r_out_valid;
    assign o_duty_x     = r_duty_x;
    assign o_duty_y     = r_duty_y;
    assign o_cursor_col = r_col;
    assign o_cursor_row = r_row;
    assign o_moved_x    = r_moved_x;
    assign o_moved_y    = r_moved_y;

endmodule
`default_nettype wire
